// ----- hw/rtl/gga_pkg.sv -----
// Package for the GGA sentence parser: field widths, character codes, status codes,
// state encodings and the control struct between the top level and the number parser.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gga_pkg;

   // Default number format: four fraction digits, five integer digits.
   localparam int FRAC_DIGITS_DEF = 4;
   localparam int INT_DIGITS_DEF  = 5;

   // Result field widths.
   localparam int LAT_W    = 30;
   localparam int ALT_W    = 31;
   localparam int STATUS_W = 3;
   localparam int FIELD_W  = 5;

   // Largest magnitude any stored value may take.
   localparam logic [63:0] FIELD_CAP = 64'd999999999;

   // Field numbers, counted in commas seen.
   localparam logic [FIELD_W-1:0] FIELD_HEADER    = 5'd0;
   localparam logic [FIELD_W-1:0] FIELD_LAT       = 5'd2;
   localparam logic [FIELD_W-1:0] FIELD_LAT_HEM   = 5'd3;
   localparam logic [FIELD_W-1:0] FIELD_LON       = 5'd4;
   localparam logic [FIELD_W-1:0] FIELD_LON_HEM   = 5'd5;
   localparam logic [FIELD_W-1:0] FIELD_ALT       = 5'd9;
   localparam logic [FIELD_W-1:0] FIELD_MAX       = 5'd31;
   localparam logic [FIELD_W-1:0] COMMAS_REQUIRED = 5'd14;

   // Character codes.
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_E      = 8'h45;
   localparam logic [7:0] CH_W      = 8'h57;

   // Expected leading field.
   localparam int HEADER_LEN = 6;
   localparam logic [2:0] HEADER_POS_FULL = 3'd6;
   localparam logic [7:0] GGA_HEADER [HEADER_LEN] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};

   // Sentence status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_NOT_GGA     = 3'd1,
      ST_FIELD_COUNT = 3'd2,
      ST_CHECKSUM    = 3'd3,
      ST_LAT_HEM     = 3'd4,
      ST_LON_HEM     = 3'd5
   } status_type;

   // Hemisphere field progress.
   typedef enum logic [1:0] {
      HEM_EMPTY  = 2'd0,
      HEM_FIRST  = 2'd1,
      HEM_SECOND = 2'd2,
      HEM_BAD    = 2'd3
   } hem_type;

   // Number parser phases.
   typedef enum logic [1:0] {
      NUM_SKIP = 2'd0,
      NUM_INT  = 2'd1,
      NUM_FRAC = 2'd2,
      NUM_DONE = 2'd3
   } num_phase_type;

   // Control from the sentence logic to the number parser.
   typedef struct packed {
      logic feed;
      logic clear;
   } num_ctrl_type;

   // Power of ten, evaluated at elaboration or on small constant indexes.
   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

// ----- hw/rtl/gga_if.sv -----
// Valid/ready channel interfaces for the GGA sentence parser: one for the
// character requests and one for the status results. Depends on gga_pkg.
interface gga_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_sentence;

   modport source (output valid, output char_in, output end_of_sentence, input ready);
   modport sink   (input valid, input char_in, input end_of_sentence, output ready);
endinterface

interface gga_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [gga_pkg::STATUS_W-1:0]        status;
   logic [gga_pkg::LAT_W-1:0]           latitude;
   logic [gga_pkg::LAT_W-1:0]           longitude;
   logic signed [gga_pkg::ALT_W-1:0]    altitude;
   logic                                south;
   logic                                west;

   modport source (output valid, output status, output latitude, output longitude,
                   output altitude, output south, output west, input ready);
   modport sink   (input valid, input status, input latitude, input longitude,
                   input altitude, input south, input west, output ready);
endinterface

// ----- hw/rtl/gga_num_parse.sv -----
// Decimal number parser for one numeric field: skips blanks, takes a sign, integer
// and fraction digits, and presents the saturated fixed-point value. Depends on gga_pkg.
module gga_num_parse #(
   parameter int FRAC_DIGITS = gga_pkg::FRAC_DIGITS_DEF,
   parameter int INT_DIGITS  = gga_pkg::INT_DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        char_in,
   input  gga_pkg::num_ctrl_type             ctrl,
   output logic signed [gga_pkg::ALT_W-1:0]  value_signed,
   output logic [gga_pkg::LAT_W-1:0]         value_unsigned
);

   localparam logic [63:0] CAP64   = gga_pkg::pow10(INT_DIGITS);
   localparam logic [63:0] SCALE64 = gga_pkg::pow10(FRAC_DIGITS);
   localparam logic [63:0] FULL64  = gga_pkg::pow10(INT_DIGITS + FRAC_DIGITS);
   localparam logic [63:0] LIMIT64 =
      (FULL64 - 64'd1 > gga_pkg::FIELD_CAP) ? gga_pkg::FIELD_CAP : FULL64 - 64'd1;
   localparam int ACC_W  = $clog2(CAP64 + 64'd1);
   localparam int ACCX_W = ACC_W + 4;
   localparam int FRAC_W = $clog2(SCALE64);
   localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);
   localparam int MAG_W  = $clog2(FULL64) + 1;

   localparam logic [ACCX_W-1:0] CAP_X   = ACCX_W'(CAP64);
   localparam logic [MAG_W-1:0]  SCALE_M = MAG_W'(SCALE64);
   localparam logic [MAG_W-1:0]  LIMIT_M = MAG_W'(LIMIT64);
   localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(FRAC_DIGITS);

   gga_pkg::num_phase_type phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [FRAC_W-1:0]      frac_ff, frac_in;
   logic [FCNT_W-1:0]      fcount_ff, fcount_in;

   logic                   digit_ok;
   logic                   blank;
   logic [3:0]             digit;
   logic [ACCX_W-1:0]      acc_next;
   logic [FRAC_W-1:0]      frac_scale;
   logic [MAG_W-1:0]       mag_raw;
   logic [MAG_W-1:0]       mag_sat;
   logic [gga_pkg::LAT_W-1:0] mag;

   // Character classes.
   assign digit_ok = gga_pkg::is_digit(char_in);
   assign digit    = char_in[3:0];
   assign blank    = (char_in == gga_pkg::CH_SPACE) ||
                     ((char_in >= gga_pkg::CH_TAB) && (char_in <= gga_pkg::CH_CR));

   // Integer accumulation with saturation at the integer cap.
   always_comb begin
      acc_next = {4'b0000, acc_ff} * ACCX_W'(10) + ACCX_W'(digit);
      if (acc_next > CAP_X) begin
         acc_next = CAP_X;
      end
   end

   // Weight of the next fraction digit, picked by the digits taken so far.
   always_comb begin
      frac_scale = '0;
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         if (fcount_ff == FCNT_W'(i)) begin
            frac_scale = FRAC_W'(gga_pkg::pow10(FRAC_DIGITS - 1 - i));
         end
      end
   end

   // Next phase of the field.
   always_comb begin
      phase_in = phase_ff;
      if (ctrl.clear) begin
         phase_in = gga_pkg::NUM_SKIP;
      end else if (ctrl.feed) begin
         unique case (phase_ff)
            gga_pkg::NUM_SKIP: begin
               if (blank) begin
                  phase_in = gga_pkg::NUM_SKIP;
               end else if (char_in == gga_pkg::CH_DOT) begin
                  phase_in = gga_pkg::NUM_FRAC;
               end else if (digit_ok || char_in == gga_pkg::CH_PLUS ||
                            char_in == gga_pkg::CH_MINUS) begin
                  phase_in = gga_pkg::NUM_INT;
               end else begin
                  phase_in = gga_pkg::NUM_DONE;
               end
            end
            gga_pkg::NUM_INT: begin
               if (digit_ok) begin
                  phase_in = gga_pkg::NUM_INT;
               end else if (char_in == gga_pkg::CH_DOT) begin
                  phase_in = gga_pkg::NUM_FRAC;
               end else begin
                  phase_in = gga_pkg::NUM_DONE;
               end
            end
            gga_pkg::NUM_FRAC: begin
               if (!digit_ok) begin
                  phase_in = gga_pkg::NUM_DONE;
               end
            end
            gga_pkg::NUM_DONE: phase_in = gga_pkg::NUM_DONE;
            default:           phase_in = gga_pkg::NUM_DONE;
         endcase
      end
   end

   // Sign, integer and fraction accumulators.
   always_comb begin
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      fcount_in = fcount_ff;
      if (ctrl.clear) begin
         neg_in    = 1'b0;
         acc_in    = '0;
         frac_in   = '0;
         fcount_in = '0;
      end else if (ctrl.feed) begin
         unique case (phase_ff)
            gga_pkg::NUM_SKIP: begin
               if (char_in == gga_pkg::CH_MINUS) begin
                  neg_in = 1'b1;
               end else if (digit_ok) begin
                  acc_in = ACC_W'(acc_next);
               end
            end
            gga_pkg::NUM_INT: begin
               if (digit_ok) begin
                  acc_in = ACC_W'(acc_next);
               end
            end
            gga_pkg::NUM_FRAC: begin
               if (digit_ok && fcount_ff < FCNT_MAX) begin
                  frac_in   = frac_ff + FRAC_W'({{(FRAC_W-4){1'b0}}, digit} * frac_scale);
                  fcount_in = fcount_ff + FCNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= gga_pkg::NUM_SKIP;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         frac_ff   <= '0;
         fcount_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         acc_ff    <= acc_in;
         frac_ff   <= frac_in;
         fcount_ff <= fcount_in;
      end
   end

   // Fixed-point value of the field so far, saturated and signed.
   assign mag_raw = MAG_W'(acc_ff) * SCALE_M + MAG_W'(frac_ff);
   assign mag_sat = (mag_raw > LIMIT_M) ? LIMIT_M : mag_raw;
   assign mag     = gga_pkg::LAT_W'(mag_sat);

   assign value_signed   = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   assign value_unsigned = neg_ff ? '0 : mag;

endmodule

// ----- hw/rtl/nmea_gga_sentence_parser.sv -----
// GGA sentence parser: one character per request, one status result per sentence.
// A final character is held in the input register, then its result is registered in the result register.
// Throughput: one character per cycle; only a final character waits on a held result.
// Reset is synchronous and active high; it clears the sentence state and the
// stored latitude, longitude, altitude and hemispheres to zero (north, east).
// Depends on gga_pkg, gga_if and gga_num_parse.
module nmea_gga_sentence_parser #(
   parameter int FRAC_DIGITS = gga_pkg::FRAC_DIGITS_DEF,
   parameter int INT_DIGITS  = gga_pkg::INT_DIGITS_DEF
) (
   input logic       clock,
   input logic       reset,
   gga_req_if.sink   req_chan,
   gga_rsp_if.source rsp_chan
);

   // Input register.
   logic       s1_valid_ff;
   logic [7:0] s1_char_ff;
   logic       s1_eos_ff;
   logic       s1_fire;

   // Sentence state.
   logic [gga_pkg::FIELD_W-1:0]       field_ff, field_in;
   logic                              header_ok_ff, header_ok_in;
   logic [2:0]                        header_pos_ff, header_pos_in;
   logic [7:0]                        xor_ff, xor_in;
   logic                              dollar_ff, dollar_in;
   logic                              star_ff, star_in;
   logic [1:0]                        hex_count_ff, hex_count_in;
   logic [7:0]                        hex_value_ff, hex_value_in;
   logic                              hex_bad_ff, hex_bad_in;
   logic [gga_pkg::LAT_W-1:0]         lat_tmp_ff, lat_tmp_in;
   logic [gga_pkg::LAT_W-1:0]         lon_tmp_ff, lon_tmp_in;
   logic signed [gga_pkg::ALT_W-1:0]  alt_tmp_ff, alt_tmp_in;
   gga_pkg::hem_type                  hem_lat_ff, hem_lat_in;
   gga_pkg::hem_type                  hem_lon_ff, hem_lon_in;

   // Stored values and result.
   logic [gga_pkg::LAT_W-1:0]         lat_ff, lat_in;
   logic [gga_pkg::LAT_W-1:0]         lon_ff, lon_in;
   logic signed [gga_pkg::ALT_W-1:0]  alt_ff, alt_in;
   logic                              south_ff, south_in;
   logic                              west_ff, west_in;
   gga_pkg::status_type               status_ff, status_in;
   logic                              rsp_valid_ff;

   // Number parser link.
   gga_pkg::num_ctrl_type             num_ctrl;
   logic signed [gga_pkg::ALT_W-1:0]  num_signed;
   logic [gga_pkg::LAT_W-1:0]         num_unsigned;
   logic                              field_end;
   logic                              num_feed;

   logic [7:0] c;
   logic [4:0] hex_dec;

   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'b0_0000;
      if (gga_pkg::is_digit(ch)) begin
         r = {1'b1, ch[3:0]};
      end else if ((ch >= gga_pkg::CH_UP_A && ch <= gga_pkg::CH_UP_F) ||
                   (ch >= gga_pkg::CH_LO_A && ch <= gga_pkg::CH_LO_F)) begin
         r = {1'b1, ch[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic gga_pkg::hem_type hem_next(input gga_pkg::hem_type code,
                                                 input logic [7:0] ch,
                                                 input logic [7:0] first,
                                                 input logic [7:0] second);
      gga_pkg::hem_type r;
      if (code != gga_pkg::HEM_EMPTY) begin
         r = gga_pkg::HEM_BAD;
      end else if (ch == first) begin
         r = gga_pkg::HEM_FIRST;
      end else if (ch == second) begin
         r = gga_pkg::HEM_SECOND;
      end else begin
         r = gga_pkg::HEM_BAD;
      end
      return r;
   endfunction

   // A final character moves on only when the result register is free or drains now.
   assign s1_fire = s1_valid_ff && (!s1_eos_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_char_ff <= req_chan.char_in;
         s1_eos_ff  <= req_chan.end_of_sentence;
      end
   end

   assign c       = s1_char_ff;
   assign hex_dec = hex_decode(c);

   // Field boundaries and number feeding for the current character.
   always_comb begin
      field_end = 1'b0;
      num_feed  = 1'b0;
      if (!star_ff) begin
         if (c == gga_pkg::CH_STAR || c == gga_pkg::CH_COMMA) begin
            field_end = 1'b1;
         end else if (field_ff == gga_pkg::FIELD_LAT || field_ff == gga_pkg::FIELD_LON ||
                      field_ff == gga_pkg::FIELD_ALT) begin
            num_feed = 1'b1;
         end
      end
   end

   assign num_ctrl.feed  = s1_fire && num_feed;
   assign num_ctrl.clear = s1_fire && (field_end || s1_eos_ff);

   gga_num_parse #(
      .FRAC_DIGITS (FRAC_DIGITS),
      .INT_DIGITS  (INT_DIGITS)
   ) u_num (
      .clock          (clock),
      .reset          (reset),
      .char_in        (c),
      .ctrl           (num_ctrl),
      .value_signed   (num_signed),
      .value_unsigned (num_unsigned)
   );

   // Sentence state update for one character.
   always_comb begin
      field_in      = field_ff;
      header_ok_in  = header_ok_ff;
      header_pos_in = header_pos_ff;
      xor_in        = xor_ff;
      dollar_in     = dollar_ff;
      star_in       = star_ff;
      hex_count_in  = hex_count_ff;
      hex_value_in  = hex_value_ff;
      hex_bad_in    = hex_bad_ff;
      lat_tmp_in    = lat_tmp_ff;
      lon_tmp_in    = lon_tmp_ff;
      alt_tmp_in    = alt_tmp_ff;
      hem_lat_in    = hem_lat_ff;
      hem_lon_in    = hem_lon_ff;

      if (star_ff) begin
         // Checksum digits; a comma after the star spoils the checksum.
         if (c == gga_pkg::CH_COMMA) begin
            hex_bad_in = 1'b1;
            if (field_ff != gga_pkg::FIELD_MAX) begin
               field_in = field_ff + gga_pkg::FIELD_W'(1);
            end
         end
         if (hex_count_ff < 2'd2) begin
            if (!hex_dec[4]) begin
               hex_bad_in = 1'b1;
            end else begin
               hex_value_in = {hex_value_ff[3:0], hex_dec[3:0]};
            end
            hex_count_in = hex_count_ff + 2'd1;
         end
      end else begin
         if (field_end) begin
            if (field_ff == gga_pkg::FIELD_HEADER &&
                header_pos_ff != gga_pkg::HEADER_POS_FULL) begin
               header_ok_in = 1'b0;
            end
            if (field_ff == gga_pkg::FIELD_LAT) begin
               lat_tmp_in = num_unsigned;
            end
            if (field_ff == gga_pkg::FIELD_LON) begin
               lon_tmp_in = num_unsigned;
            end
            if (field_ff == gga_pkg::FIELD_ALT) begin
               alt_tmp_in = num_signed;
            end
         end
         if (c == gga_pkg::CH_STAR) begin
            star_in = 1'b1;
         end else begin
            if (dollar_ff) begin
               xor_in = xor_ff ^ c;
            end
            if (c == gga_pkg::CH_DOLLAR) begin
               dollar_in = 1'b1;
            end
            if (c == gga_pkg::CH_COMMA) begin
               if (field_ff != gga_pkg::FIELD_MAX) begin
                  field_in = field_ff + gga_pkg::FIELD_W'(1);
               end
            end else begin
               if (field_ff == gga_pkg::FIELD_HEADER) begin
                  if (header_pos_ff < gga_pkg::HEADER_POS_FULL &&
                      c == gga_pkg::GGA_HEADER[header_pos_ff]) begin
                     header_pos_in = header_pos_ff + 3'd1;
                  end else begin
                     header_ok_in = 1'b0;
                  end
               end
               if (field_ff == gga_pkg::FIELD_LAT_HEM) begin
                  hem_lat_in = hem_next(hem_lat_ff, c, gga_pkg::CH_N, gga_pkg::CH_S);
               end
               if (field_ff == gga_pkg::FIELD_LON_HEM) begin
                  hem_lon_in = hem_next(hem_lon_ff, c, gga_pkg::CH_E, gga_pkg::CH_W);
               end
            end
         end
      end
   end

   // Sentence verdict and stored-value update on the final character.
   always_comb begin
      lat_in    = lat_ff;
      lon_in    = lon_ff;
      alt_in    = alt_ff;
      south_in  = south_ff;
      west_in   = west_ff;
      status_in = gga_pkg::ST_OK;
      if (!header_ok_in || (field_in == gga_pkg::FIELD_HEADER && !star_in)) begin
         status_in = gga_pkg::ST_NOT_GGA;
      end else if (field_in != gga_pkg::COMMAS_REQUIRED || !star_in) begin
         status_in = gga_pkg::ST_FIELD_COUNT;
      end else if (hex_bad_in || hex_count_in < 2'd2 || hex_value_in != xor_in) begin
         status_in = gga_pkg::ST_CHECKSUM;
      end else begin
         lat_in = lat_tmp_in;
         lon_in = lon_tmp_in;
         alt_in = alt_tmp_in;
         if (hem_lat_in == gga_pkg::HEM_FIRST || hem_lat_in == gga_pkg::HEM_SECOND) begin
            south_in = (hem_lat_in == gga_pkg::HEM_SECOND);
            if (hem_lon_in == gga_pkg::HEM_FIRST || hem_lon_in == gga_pkg::HEM_SECOND) begin
               west_in = (hem_lon_in == gga_pkg::HEM_SECOND);
            end else begin
               status_in = gga_pkg::ST_LON_HEM;
            end
         end else begin
            status_in = gga_pkg::ST_LAT_HEM;
         end
      end
   end

   // Sentence registers: cleared at reset and after every final character.
   always_ff @(posedge clock) begin
      if (reset || (s1_fire && s1_eos_ff)) begin
         field_ff      <= '0;
         header_ok_ff  <= 1'b1;
         header_pos_ff <= '0;
         xor_ff        <= '0;
         dollar_ff     <= 1'b0;
         star_ff       <= 1'b0;
         hex_count_ff  <= '0;
         hex_value_ff  <= '0;
         hex_bad_ff    <= 1'b0;
         lat_tmp_ff    <= '0;
         lon_tmp_ff    <= '0;
         alt_tmp_ff    <= '0;
         hem_lat_ff    <= gga_pkg::HEM_EMPTY;
         hem_lon_ff    <= gga_pkg::HEM_EMPTY;
      end else if (s1_fire) begin
         field_ff      <= field_in;
         header_ok_ff  <= header_ok_in;
         header_pos_ff <= header_pos_in;
         xor_ff        <= xor_in;
         dollar_ff     <= dollar_in;
         star_ff       <= star_in;
         hex_count_ff  <= hex_count_in;
         hex_value_ff  <= hex_value_in;
         hex_bad_ff    <= hex_bad_in;
         lat_tmp_ff    <= lat_tmp_in;
         lon_tmp_ff    <= lon_tmp_in;
         alt_tmp_ff    <= alt_tmp_in;
         hem_lat_ff    <= hem_lat_in;
         hem_lon_ff    <= hem_lon_in;
      end
   end

   // Stored values and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff       <= '0;
         lon_ff       <= '0;
         alt_ff       <= '0;
         south_ff     <= 1'b0;
         west_ff      <= 1'b0;
         status_ff    <= gga_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_eos_ff) begin
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         alt_ff       <= alt_in;
         south_ff     <= south_in;
         west_ff      <= west_in;
         status_ff    <= status_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.latitude  = lat_ff;
   assign rsp_chan.longitude = lon_ff;
   assign rsp_chan.altitude  = alt_ff;
   assign rsp_chan.south     = south_ff;
   assign rsp_chan.west      = west_ff;

endmodule

// ----- bench/tb_nmea_gga_sentence_parser.sv -----
`timescale 1ns / 100ps
// Testbench for the GGA sentence parser: sends NMEA sentences one character per request
// and checks each status report against a parser model kept inside the bench.
// Depends on gga_pkg, the gga_req_if and gga_rsp_if interfaces and nmea_gga_sentence_parser.
module tb_nmea_gga_sentence_parser;

   // Ways to close a sentence after its body.
   typedef enum int {
      TAIL_UPPER, TAIL_LOWER, TAIL_WRONG, TAIL_BAD_HEX,
      TAIL_SHORT, TAIL_COMMA, TAIL_EXTRA, TAIL_NONE
   } tail_type;

   // One status report as the block should present it.
   typedef struct {
      gga_pkg::status_type              status;
      logic [gga_pkg::LAT_W-1:0]        latitude;
      logic [gga_pkg::LAT_W-1:0]        longitude;
      logic signed [gga_pkg::ALT_W-1:0] altitude;
      logic                             south;
      logic                             west;
   } report_type;

   function automatic longint unsigned decade(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   localparam int FRAC  = gga_pkg::FRAC_DIGITS_DEF;
   localparam int WHOLE = gga_pkg::INT_DIGITS_DEF;
   localparam longint unsigned FRAC_SCALE = decade(FRAC);
   localparam longint unsigned WHOLE_CAP  = decade(WHOLE);
   localparam longint unsigned MAG_LIMIT  =
      (decade(WHOLE + FRAC) - 1 > gga_pkg::FIELD_CAP) ? gga_pkg::FIELD_CAP :
      decade(WHOLE + FRAC) - 1;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_CHARS = 250;

   logic clock = 1'b0;
   logic reset;

   gga_req_if char_bus ();
   gga_rsp_if report_bus ();

   nmea_gga_sentence_parser i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (char_bus),
      .rsp_chan (report_bus)
   );

   always #1 clock = ~clock;

   // Stored fix, as the block should hold it.
   logic [gga_pkg::LAT_W-1:0]        fix_lat, fix_lon;
   logic signed [gga_pkg::ALT_W-1:0] fix_alt;
   logic                             fix_south, fix_west;

   // Per-sentence parse state.
   int                     commas;
   logic                   header_good;
   int                     header_at;
   logic [7:0]             run_xor;
   logic                   got_dollar, got_star;
   int                     tail_cnt;
   logic [7:0]             tail_val;
   logic                   tail_bad;
   longint unsigned        num_int, num_frac;
   int                     frac_cnt;
   gga_pkg::num_phase_type num_stage;
   logic                   num_minus;
   logic [gga_pkg::LAT_W-1:0]        lat_pend, lon_pend;
   logic signed [gga_pkg::ALT_W-1:0] alt_pend;
   gga_pkg::hem_type       lat_hem, lon_hem;

   report_type pending_reports[$];

   int   mismatches = 0;
   int   cycle_count = 0;
   int   chars_sent = 0;
   int   sentences_closed = 0;
   int   burst_left = 0;
   logic steady = 1'b0;
   logic [7:0] ready_mask = 8'hFF;
   int   mask_age = 0;

   string alt_heads[6] = '{"GPRMC", "GPGG", "GPGGAA", "gpgga", "GNGGA", ""};
   string odd_numbers[7] = '{"1e5", "..5", "-.", "12a3", ".", "-", "+-1"};

   // ---------------------------------------------------------------- parser model

   task automatic number_clear();
      num_int = 0;
      num_frac = 0;
      frac_cnt = 0;
      num_stage = gga_pkg::NUM_SKIP;
      num_minus = 1'b0;
   endtask

   task automatic sentence_clear();
      commas = 0;
      header_good = 1'b1;
      header_at = 0;
      run_xor = '0;
      got_dollar = 1'b0;
      got_star = 1'b0;
      tail_cnt = 0;
      tail_val = '0;
      tail_bad = 1'b0;
      number_clear();
      lat_pend = '0;
      lon_pend = '0;
      alt_pend = '0;
      lat_hem = gga_pkg::HEM_EMPTY;
      lon_hem = gga_pkg::HEM_EMPTY;
   endtask

   // Number fields read like atof: blanks, sign, digits, point, digits, then stop.
   task automatic number_take(input logic [7:0] c);
      logic digit;
      digit = (c >= gga_pkg::CH_ZERO) && (c <= gga_pkg::CH_NINE);
      if (num_stage == gga_pkg::NUM_SKIP) begin
         if (c == gga_pkg::CH_PLUS || c == gga_pkg::CH_MINUS) begin
            num_minus = (c == gga_pkg::CH_MINUS);
            num_stage = gga_pkg::NUM_INT;
         end else if (c == gga_pkg::CH_DOT) begin
            num_stage = gga_pkg::NUM_FRAC;
         end else if (digit) begin
            num_stage = gga_pkg::NUM_INT;
         end else if (!(c == gga_pkg::CH_SPACE ||
                        (c >= gga_pkg::CH_TAB && c <= gga_pkg::CH_CR))) begin
            num_stage = gga_pkg::NUM_DONE;
         end
         // Only a leading digit goes on to be accumulated.
         if (!digit) return;
      end
      case (num_stage)
         gga_pkg::NUM_INT: begin
            if (digit) begin
               num_int = num_int * 10 + (c - gga_pkg::CH_ZERO);
               if (num_int > WHOLE_CAP) num_int = WHOLE_CAP;
            end else if (c == gga_pkg::CH_DOT) begin
               num_stage = gga_pkg::NUM_FRAC;
            end else begin
               num_stage = gga_pkg::NUM_DONE;
            end
         end
         gga_pkg::NUM_FRAC: begin
            if (!digit) begin
               num_stage = gga_pkg::NUM_DONE;
            end else if (frac_cnt < FRAC) begin
               num_frac = num_frac * 10 + (c - gga_pkg::CH_ZERO);
               frac_cnt++;
            end
         end
         default: ;
      endcase
   endtask

   function automatic longint number_value();
      longint unsigned mag;
      mag = num_int * FRAC_SCALE + num_frac * decade(FRAC - frac_cnt);
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;
      return num_minus ? -longint'(mag) : longint'(mag);
   endfunction

   // Latitude and longitude are unsigned; negative readings become zero.
   function automatic logic [gga_pkg::LAT_W-1:0] number_unsigned();
      longint v;
      v = number_value();
      return (v < 0) ? '0 : v[gga_pkg::LAT_W-1:0];
   endfunction

   function automatic gga_pkg::hem_type hem_step(input gga_pkg::hem_type code,
                                                 input logic [7:0] c,
                                                 input logic [7:0] first,
                                                 input logic [7:0] second);
      if (code != gga_pkg::HEM_EMPTY) return gga_pkg::HEM_BAD;
      if (c == first) return gga_pkg::HEM_FIRST;
      if (c == second) return gga_pkg::HEM_SECOND;
      return gga_pkg::HEM_BAD;
   endfunction

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= gga_pkg::CH_ZERO && c <= gga_pkg::CH_NINE) return c - gga_pkg::CH_ZERO;
      if (c >= gga_pkg::CH_UP_A && c <= gga_pkg::CH_UP_F) return c - gga_pkg::CH_UP_A + 10;
      if (c >= gga_pkg::CH_LO_A && c <= gga_pkg::CH_LO_F) return c - gga_pkg::CH_LO_A + 10;
      return -1;
   endfunction

   // A comma or the star closes the current field.
   task automatic field_close();
      longint v;
      if (commas == gga_pkg::FIELD_HEADER && header_at != gga_pkg::HEADER_LEN)
         header_good = 1'b0;
      if (commas == gga_pkg::FIELD_LAT) lat_pend = number_unsigned();
      if (commas == gga_pkg::FIELD_LON) lon_pend = number_unsigned();
      if (commas == gga_pkg::FIELD_ALT) begin
         v = number_value();
         alt_pend = v[gga_pkg::ALT_W-1:0];
      end
      number_clear();
   endtask

   // Advance the model by one accepted character; a final character yields a report.
   task automatic parse_char(input logic [7:0] c, input logic eos);
      int                  nib;
      gga_pkg::status_type verdict;
      report_type          rep;
      if (got_star) begin
         // After the star only the two checksum digits matter, and no comma may follow.
         if (c == gga_pkg::CH_COMMA) begin
            tail_bad = 1'b1;
            if (commas < gga_pkg::FIELD_MAX) commas++;
         end
         if (tail_cnt < 2) begin
            nib = hex_nibble(c);
            if (nib < 0) tail_bad = 1'b1;
            else tail_val = {tail_val[3:0], nib[3:0]};
            tail_cnt++;
         end
      end else if (c == gga_pkg::CH_STAR) begin
         field_close();
         got_star = 1'b1;
      end else begin
         if (got_dollar) run_xor ^= c;
         if (c == gga_pkg::CH_DOLLAR) got_dollar = 1'b1;
         if (c == gga_pkg::CH_COMMA) begin
            field_close();
            if (commas < gga_pkg::FIELD_MAX) commas++;
         end else begin
            if (commas == gga_pkg::FIELD_HEADER) begin
               if (header_at < gga_pkg::HEADER_LEN && c == gga_pkg::GGA_HEADER[header_at])
                  header_at++;
               else
                  header_good = 1'b0;
            end
            if (commas == gga_pkg::FIELD_LAT || commas == gga_pkg::FIELD_LON ||
                commas == gga_pkg::FIELD_ALT)
               number_take(c);
            if (commas == gga_pkg::FIELD_LAT_HEM)
               lat_hem = hem_step(lat_hem, c, gga_pkg::CH_N, gga_pkg::CH_S);
            if (commas == gga_pkg::FIELD_LON_HEM)
               lon_hem = hem_step(lon_hem, c, gga_pkg::CH_E, gga_pkg::CH_W);
         end
      end

      if (eos) begin
         if (!header_good || (commas == gga_pkg::FIELD_HEADER && !got_star)) begin
            verdict = gga_pkg::ST_NOT_GGA;
         end else if (commas != gga_pkg::COMMAS_REQUIRED || !got_star) begin
            verdict = gga_pkg::ST_FIELD_COUNT;
         end else if (tail_bad || tail_cnt < 2 || tail_val != run_xor) begin
            verdict = gga_pkg::ST_CHECKSUM;
         end else begin
            // Numbers are stored first, then the hemispheres in order.
            fix_lat = lat_pend;
            fix_lon = lon_pend;
            fix_alt = alt_pend;
            if (lat_hem != gga_pkg::HEM_FIRST && lat_hem != gga_pkg::HEM_SECOND) begin
               verdict = gga_pkg::ST_LAT_HEM;
            end else begin
               fix_south = (lat_hem == gga_pkg::HEM_SECOND);
               if (lon_hem != gga_pkg::HEM_FIRST && lon_hem != gga_pkg::HEM_SECOND) begin
                  verdict = gga_pkg::ST_LON_HEM;
               end else begin
                  fix_west = (lon_hem == gga_pkg::HEM_SECOND);
                  verdict = gga_pkg::ST_OK;
               end
            end
         end
         rep.status = verdict;
         rep.latitude = fix_lat;
         rep.longitude = fix_lon;
         rep.altitude = fix_alt;
         rep.south = fix_south;
         rep.west = fix_west;
         pending_reports.insert(pending_reports.size(), rep);
         sentence_clear();
      end
   endtask

   // ---------------------------------------------------------------- driving

   // Send one character request; unless steady, the sender idles between bursts of random length.
   task automatic send_char(input logic [7:0] c, input logic eos);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady) begin
            repeat ($urandom_range(1, 6)) begin
               @(negedge clock);
               char_bus.valid <= 1'b0;
            end
         end
      end
      burst_left--;
      @(negedge clock);
      char_bus.valid <= 1'b1;
      char_bus.char_in <= c;
      char_bus.end_of_sentence <= eos;
      @(posedge clock);
      while (!char_bus.ready) @(posedge clock);
      parse_char(c, eos);
      chars_sent++;
      if (eos) sentences_closed++;
   endtask

   // Send a string; its last character closes the sentence.
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic string gga_frame(input string body, input tail_type tail);
      logic [7:0] x;
      string      hx;
      x = '0;
      for (int i = 0; i < body.len(); i++) x ^= body[i];
      hx = $sformatf("%02X", x);
      case (tail)
         TAIL_LOWER:   hx = $sformatf("%02x", x);
         TAIL_WRONG:   hx = $sformatf("%02X", x ^ 8'($urandom_range(1, 255)));
         TAIL_BAD_HEX: hx = {hx.substr(0, 0), ($urandom_range(0, 1) != 0) ? "G" : "z"};
         TAIL_SHORT:   hx = hx.substr(0, 0);
         TAIL_COMMA:   hx = {hx, ","};
         TAIL_EXTRA:   hx = {hx, "\r\n"};
         TAIL_NONE:    return {"$", body};
         default: ;
      endcase
      return {"$", body, "*", hx};
   endfunction

   // A short GGA body: empty time, quality 1, altitude in meters, the rest empty.
   function automatic string gga_body(input string lat, input string ns, input string lon,
                                      input string ew, input string alt);
      return {"GPGGA,,", lat, ",", ns, ",", lon, ",", ew, ",1,,,", alt, ",M,,,,"};
   endfunction

   function automatic string digit_run(input int n);
      string s;
      s = "";
      repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
      return s;
   endfunction

   // Any nonzero byte except the field and checksum separators.
   function automatic string rand_token(input int max_len);
      string      s;
      logic [7:0] c;
      s = "";
      repeat ($urandom_range(0, max_len)) begin
         c = $urandom_range(1, 255);
         if (c == gga_pkg::CH_COMMA || c == gga_pkg::CH_STAR) c = gga_pkg::CH_PLUS;
         s = $sformatf("%s%c", s, c);
      end
      return s;
   endfunction

   function automatic string rand_number(input int whole);
      string      s;
      logic [7:0] b;
      case ($urandom_range(0, 11))
         0: s = "";
         1: s = digit_run($urandom_range(6, 12));
         2: s = {digit_run($urandom_range(1, 7)), ".", digit_run($urandom_range(5, 9))};
         7: s = {"-", digit_run($urandom_range(1, 4)), ".", digit_run($urandom_range(0, 3))};
         8: s = {"+", digit_run($urandom_range(0, 4)), ".", digit_run($urandom_range(1, 3))};
         9: begin
            // Leading blanks of every kind the parser skips.
            s = "";
            repeat ($urandom_range(1, 3)) begin
               b = ($urandom_range(0, 5) == 5) ? gga_pkg::CH_SPACE :
                   8'($urandom_range(9, 13));
               s = $sformatf("%s%c", s, b);
            end
            s = {s, digit_run($urandom_range(1, whole)), ".", digit_run(2)};
         end
         10: s = odd_numbers[$urandom_range(0, 6)];
         11: s = rand_token(4);
         default: s = {digit_run(whole), ".", digit_run($urandom_range(1, 4))};
      endcase
      return s;
   endfunction

   function automatic string rand_hem(input string first, input string second);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return first;
         4, 5, 6, 7: return second;
         8: return "";
         default: return ($urandom_range(0, 1) != 0) ? {first, second} : rand_token(2);
      endcase
   endfunction

   // A GGA frame with random content, mostly well formed.
   function automatic string random_frame();
      string    f[$];
      string    body;
      int       k;
      tail_type tail;
      f.insert(f.size(), ($urandom_range(0, 7) != 0) ? "GPGGA" : alt_heads[$urandom_range(0, 5)]);
      f.insert(f.size(), ($urandom_range(0, 1) != 0) ? "" : digit_run(6));
      f.insert(f.size(), rand_number(4));
      f.insert(f.size(), rand_hem("N", "S"));
      f.insert(f.size(), rand_number(5));
      f.insert(f.size(), rand_hem("E", "W"));
      repeat (3) f.insert(f.size(), ($urandom_range(0, 2) == 0) ? rand_token(3) : "");
      f.insert(f.size(), rand_number(3));
      f.insert(f.size(), "M");
      f.insert(f.size(), "");
      f.insert(f.size(), "M");
      f.insert(f.size(), "");
      f.insert(f.size(), "");
      // Now and then one field too few or too many.
      if ($urandom_range(0, 9) == 0) begin
         if ($urandom_range(0, 1) != 0) f.delete($urandom_range(1, f.size() - 1));
         else f.insert(f.size(), rand_token(2));
      end
      body = f[0];
      for (int i = 1; i < f.size(); i++) body = {body, ",", f[i]};
      k = $urandom_range(0, 16);
      tail = (k < 10) ? TAIL_UPPER : tail_type'(k - 9);
      return gga_frame(body, tail);
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_valid_fixes();
      send_text(gga_frame(gga_body("4807.038", "N", "01131.000", "E", "545.4"), TAIL_UPPER));
      send_text(gga_frame(gga_body("0000.0000", "S", "00000.0000", "W", "-0.5"), TAIL_LOWER));
      // Saturation of latitude and altitude; a negative longitude reads as zero.
      send_text(gga_frame(gga_body("99999999999.99999", "N", "-12.5", "E", "-99999999999"),
                          TAIL_UPPER));
      send_text(gga_frame(gga_body("99999.9999", "S", "100000", "W", "+99999.99995"),
                          TAIL_UPPER));
      send_text(gga_frame(gga_body(" \t+12.34567", "N", "\n\013\014\r7", "W", ".5"),
                          TAIL_UPPER));
      // Malformed numbers and exponents stop the parse early.
      send_text(gga_frame(gga_body("abc", "S", "1e5", "E", "--3"), TAIL_UPPER));
      send_text(gga_frame(gga_body("", "N", "", "E", ""), TAIL_EXTRA));
      send_text(gga_frame(gga_body("+.", "N", "-", "W", "12.3.4"), TAIL_LOWER));
   endtask

   task automatic test_rejects();
      string fix_body, rest;
      fix_body = gga_body("4807.038", "N", "01131.000", "E", "545.4");
      rest = fix_body.substr(5, fix_body.len() - 1);
      // Wrong leading field.
      send_text(gga_frame({"GPRMC", rest}, TAIL_UPPER));
      send_text(gga_frame({"GPGGAX", rest}, TAIL_UPPER));
      send_text(gga_frame({"GPGG", rest}, TAIL_UPPER));
      send_text({"x", gga_frame(fix_body, TAIL_UPPER)});
      send_text("$GPGGA");
      send_text("*");
      // Field count and missing star.
      send_text(gga_frame(fix_body.substr(0, fix_body.len() - 2), TAIL_UPPER));
      send_text(gga_frame({fix_body, ","}, TAIL_UPPER));
      send_text(gga_frame(fix_body, TAIL_NONE));
      // Checksum faults.
      send_text(gga_frame(fix_body, TAIL_WRONG));
      send_text(gga_frame(fix_body, TAIL_BAD_HEX));
      send_text(gga_frame(fix_body, TAIL_SHORT));
      send_text(gga_frame(fix_body, TAIL_COMMA));
      // Hemisphere faults; the numbers are stored regardless.
      send_text(gga_frame(gga_body("1234.5", "", "2345.6", "W", "-7"), TAIL_UPPER));
      send_text(gga_frame(gga_body("3456.7", "NS", "4567.8", "X", "8"), TAIL_UPPER));
      send_text(gga_frame(gga_body("5678.9", "S", "6789.1", "w", "9"), TAIL_UPPER));
      send_text(gga_frame(gga_body("1.1", "N", "2.2", "E ", "3.3"), TAIL_UPPER));
   endtask

   task automatic test_random_sentences();
      int chars_base;
      string frame;
      chars_base = chars_sent;
      while (chars_sent - chars_base < RANDOM_CHARS) begin
         steady = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0: begin
               // Raw bytes of any value, closed by a final character.
               repeat ($urandom_range(0, 11)) send_char($urandom_range(0, 255), 1'b0);
               send_char($urandom_range(0, 255), 1'b1);
            end
            1: begin
               frame = random_frame();
               send_text(frame.substr(0, $urandom_range(0, frame.len() - 1)));
            end
            default: send_text(random_frame());
         endcase
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic compare_field(input string name, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Each report taken from the block is matched against the oldest one due.
   always @(posedge clock) begin
      report_type want;
      if (!reset && report_bus.valid && report_bus.ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: report arrived with none due, expected nothing, got status %0d",
                     $time, report_bus.status);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("status", want.status, report_bus.status);
            compare_field("latitude", want.latitude, report_bus.latitude);
            compare_field("longitude", want.longitude, report_bus.longitude);
            compare_field("altitude", want.altitude, report_bus.altitude);
            compare_field("south", want.south, report_bus.south);
            compare_field("west", want.west, report_bus.west);
         end
      end
   end

   // Receiver stalls follow a rotating mask that changes every so often.
   always @(negedge clock) begin
      if (mask_age == 0) begin
         ready_mask = $urandom_range(1, 255);
         mask_age = $urandom_range(16, 96);
      end
      mask_age--;
      ready_mask = {ready_mask[0], ready_mask[7:1]};
      report_bus.ready <= steady | ready_mask[0];
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** nmea_gga_sentence_parser: FAILED **");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      char_bus.valid = 1'b0;
      char_bus.char_in = '0;
      char_bus.end_of_sentence = 1'b0;
      report_bus.ready = 1'b0;
      fix_lat = '0;
      fix_lon = '0;
      fix_alt = '0;
      fix_south = 1'b0;
      fix_west = 1'b0;
      sentence_clear();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_valid_fixes();
      test_rejects();
      test_random_sentences();

      @(negedge clock);
      char_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("** nmea_gga_sentence_parser: PASSED **");
      else $display("** nmea_gga_sentence_parser: FAILED **");
      $finish;
   end

endmodule
